FILE: rtl/core/fdg_pkg.sv
// Shared types, constants and helpers for the staggered-grid acoustic step.
// Used by fdg_grid_mem, fdg_update and acoustic_staggered_fd_step_3d.
package fdg_pkg;

	// default grid size per axis
	localparam int GRID_Z_DEF = 32;
	localparam int GRID_X_DEF = 32;
	localparam int GRID_Y_DEF = 32;

	// fixed number format of the value fields
	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 24;
	localparam int ACC_WIDTH     = 2 * VALUE_WIDTH;
	localparam int COEF_WIDTH    = 27;
	localparam int CFG_WIDTH     = 5;
	localparam int IDX_WIDTH     = 5;
	localparam int NUM_GRIDS     = 8;
	localparam int HALO          = 3;

	// stencil coefficients, rounded to nearest at FRACTION_BITS
	localparam longint COEF1 = longint'(75) << (FRACTION_BITS - 6);
	localparam longint COEF2 = -(((longint'(25) << FRACTION_BITS) + 192) / 384);
	localparam longint COEF3 = ((longint'(3) << FRACTION_BITS) + 320) / 640;

	localparam longint VMAX = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
	localparam longint VMIN = -VMAX - 1;

	typedef logic signed [VALUE_WIDTH-1:0] word_t;
	typedef logic signed [COEF_WIDTH-1:0]  coef_t;
	typedef logic signed [ACC_WIDTH-1:0]   acc_t;

	// request operations
	typedef enum logic [1:0] {
		OP_LOAD = 2'd0,
		OP_READ = 2'd1,
		OP_STEP = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	// grid codes
	localparam logic [2:0] G_P   = 3'd0;
	localparam logic [2:0] G_VX  = 3'd1;
	localparam logic [2:0] G_VY  = 3'd2;
	localparam logic [2:0] G_VZ  = 3'd3;
	localparam logic [2:0] G_BX  = 3'd4;
	localparam logic [2:0] G_BY  = 3'd5;
	localparam logic [2:0] G_BZ  = 3'd6;
	localparam logic [2:0] G_MOD = 3'd7;

	// configuration register indexes
	localparam logic [2:0] CFG_Z_BEGIN = 3'd0;
	localparam logic [2:0] CFG_Z_END   = 3'd1;
	localparam logic [2:0] CFG_X_BEGIN = 3'd2;
	localparam logic [2:0] CFG_X_END   = 3'd3;
	localparam logic [2:0] CFG_Y_BEGIN = 3'd4;
	localparam logic [2:0] CFG_Y_END   = 3'd5;

	// sequencer to datapath controls
	typedef struct packed {
		logic       tap;
		logic       first;
		logic       clear;
		logic [2:0] coef;
		logic [1:0] axis;
		logic       phase;
		logic       fin_a;
		logic       fin_b;
		logic       fin_c;
		logic [1:0] unit;
	} dp_ctl_t;

	// signed coefficient per tap: even taps add, odd taps subtract
	function automatic coef_t coef_lookup(input logic [2:0] sel);
		coef_t c;
		case (sel)
			3'd0:    c = coef_t'(COEF1);
			3'd1:    c = coef_t'(-COEF1);
			3'd2:    c = coef_t'(COEF2);
			3'd3:    c = coef_t'(-COEF2);
			3'd4:    c = coef_t'(COEF3);
			3'd5:    c = coef_t'(-COEF3);
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

FILE: rtl/core/fdg_grid_mem.sv
// One grid store: synchronous RAM, one write and one read port, registered read.
// Depends on fdg_pkg for the word type.
module fdg_grid_mem #(
	parameter int DEPTH = 32768,
	parameter int AW    = 15
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  fdg_pkg::word_t       wdata,
	input  logic [AW-1:0]        raddr,
	output fdg_pkg::word_t       rdata
);

	fdg_pkg::word_t mem_q [DEPTH];
	fdg_pkg::word_t rdata_q;

	// write on one port, registered read on the other
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/core/fdg_update.sv
// Stencil datapath: tap multiply and accumulate, then round, scale and update.
// Depends on fdg_pkg for types, coefficients and the control struct.
module fdg_update (
	input  logic              clk,
	input  logic              arst_n,
	input  fdg_pkg::dp_ctl_t  ctl,
	input  fdg_pkg::word_t    rdata [fdg_pkg::NUM_GRIDS],
	output fdg_pkg::word_t    wr_data,
	output logic              sat_hit
);

	localparam int RND_WIDTH = fdg_pkg::ACC_WIDTH - fdg_pkg::FRACTION_BITS;
	localparam int TAP_WIDTH = fdg_pkg::VALUE_WIDTH + fdg_pkg::COEF_WIDTH;

	typedef logic signed [RND_WIDTH-1:0] rnd_t;
	typedef logic signed [RND_WIDTH:0]   wide_t;

	localparam fdg_pkg::acc_t HALF = fdg_pkg::acc_t'(longint'(1) << (fdg_pkg::FRACTION_BITS - 1));
	localparam wide_t W_MAX = wide_t'(fdg_pkg::VMAX);
	localparam wide_t W_MIN = wide_t'(fdg_pkg::VMIN);

	// round to nearest, ties toward plus infinity
	function automatic rnd_t round_q(input fdg_pkg::acc_t v);
		fdg_pkg::acc_t t;
		t = v + HALF;
		return $signed(t[fdg_pkg::ACC_WIDTH-1:fdg_pkg::FRACTION_BITS]);
	endfunction

	logic                  tap_s1, first_s1, phase_s1;
	logic [2:0]            coef_s1;
	logic [1:0]            axis_s1;
	logic                  tap_s2;
	logic [1:0]            axis_s2;
	fdg_pkg::acc_t         prod_s2;
	fdg_pkg::acc_t         acc_q [3];
	fdg_pkg::word_t        old_q [3];
	fdg_pkg::word_t        fac_q [3];
	fdg_pkg::word_t        sv_q;
	fdg_pkg::acc_t         mprod_q;
	fdg_pkg::word_t        new_q;

	fdg_pkg::word_t              tap_word;
	logic signed [TAP_WIDTH-1:0] tap_prod;
	wide_t                       acc_rnd;
	wide_t                       diff;
	logic                        ovf_a, ovf_c;

	// pick the stencil source: pressure in the velocity sweep, one velocity otherwise
	always_comb begin
		if (!phase_s1) begin
			tap_word = rdata[fdg_pkg::G_P];
		end else begin
			case (axis_s1)
				2'd0:    tap_word = rdata[fdg_pkg::G_VX];
				2'd1:    tap_word = rdata[fdg_pkg::G_VY];
				default: tap_word = rdata[fdg_pkg::G_VZ];
			endcase
		end
		tap_prod = tap_word * fdg_pkg::coef_lookup(coef_s1);
	end

	// advance tap tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1   <= 1'b0;
			first_s1 <= 1'b0;
			tap_s2   <= 1'b0;
		end else begin
			tap_s1   <= ctl.tap;
			first_s1 <= ctl.first;
			tap_s2   <= tap_s1;
		end
	end

	// tap payload stages and accumulators
	always_ff @(posedge clk) begin
		coef_s1  <= ctl.coef;
		axis_s1  <= ctl.axis;
		phase_s1 <= ctl.phase;
		prod_s2  <= fdg_pkg::acc_t'(tap_prod);
		axis_s2  <= phase_s1 ? 2'd0 : axis_s1;
		if (ctl.clear) begin
			for (int a = 0; a < 3; a++) begin
				acc_q[a] <= '0;
			end
		end else if (tap_s2) begin
			acc_q[axis_s2] <= acc_q[axis_s2] + prod_s2;
		end
		// hold old values and factors of the current point
		if (first_s1) begin
			if (!phase_s1) begin
				for (int a = 0; a < 3; a++) begin
					old_q[a] <= rdata[int'(fdg_pkg::G_VX) + a];
					fac_q[a] <= rdata[int'(fdg_pkg::G_BX) + a];
				end
			end else begin
				old_q[0] <= rdata[fdg_pkg::G_P];
				fac_q[0] <= rdata[fdg_pkg::G_MOD];
			end
		end
	end

	// saturation checks of both update stages
	always_comb begin
		acc_rnd = wide_t'(round_q(acc_q[ctl.unit]));
		ovf_a   = (acc_rnd > W_MAX) || (acc_rnd < W_MIN);
		diff    = wide_t'(old_q[ctl.unit]) - wide_t'(round_q(mprod_q));
		ovf_c   = (diff > W_MAX) || (diff < W_MIN);
	end

	// round and clip sum, scale by factor, subtract from old value
	always_ff @(posedge clk) begin
		if (ctl.fin_a) begin
			if (acc_rnd > W_MAX) begin
				sv_q <= fdg_pkg::word_t'(fdg_pkg::VMAX);
			end else if (acc_rnd < W_MIN) begin
				sv_q <= fdg_pkg::word_t'(fdg_pkg::VMIN);
			end else begin
				sv_q <= acc_rnd[fdg_pkg::VALUE_WIDTH-1:0];
			end
		end
		if (ctl.fin_b) begin
			mprod_q <= sv_q * fac_q[ctl.unit];
		end
		if (ctl.fin_c) begin
			if (diff > W_MAX) begin
				new_q <= fdg_pkg::word_t'(fdg_pkg::VMAX);
			end else if (diff < W_MIN) begin
				new_q <= fdg_pkg::word_t'(fdg_pkg::VMIN);
			end else begin
				new_q <= diff[fdg_pkg::VALUE_WIDTH-1:0];
			end
		end
	end

	assign wr_data = new_q;
	assign sat_hit = (ctl.fin_a && ovf_a) || (ctl.fin_c && ovf_c);

endmodule

FILE: rtl/core/acoustic_staggered_fd_step_3d.sv
// Top level of the staggered-grid acoustic step: sequencer, grid stores, datapath.
// Depends on fdg_pkg, fdg_grid_mem and fdg_update.

// Load and no-op requests answer straight from idle and a read through the read
// state. A step sweeps the box twice, one point at a time: per point 18 stencil
// reads issued one per cycle through the single read port of the source grid, a
// drain of the multiply-accumulate pipeline, then the FIN_A, FIN_B, FIN_C and
// WRITE states per updated field through the shared round/scale/update unit, three
// fields in the velocity sweep and one in the pressure sweep. The default box is
// 26 x 26 x 26. The grid stores need no clearing after reset.
module acoustic_staggered_fd_step_3d #(
	parameter int GRID_Z = fdg_pkg::GRID_Z_DEF,
	parameter int GRID_X = fdg_pkg::GRID_X_DEF,
	parameter int GRID_Y = fdg_pkg::GRID_Y_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [fdg_pkg::CFG_WIDTH-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        operation,
	input  logic [2:0]                        field_select,
	input  logic [fdg_pkg::IDX_WIDTH-1:0]     z_index,
	input  logic [fdg_pkg::IDX_WIDTH-1:0]     x_index,
	input  logic [fdg_pkg::IDX_WIDTH-1:0]     y_index,
	input  logic signed [fdg_pkg::VALUE_WIDTH-1:0] load_value,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fdg_pkg::VALUE_WIDTH-1:0] read_value,
	output logic                              status
);

	localparam int DEPTH    = GRID_Z * GRID_X * GRID_Y;
	localparam int AW       = $clog2(DEPTH);
	localparam int ZW       = $clog2(GRID_Z);
	localparam int XW       = $clog2(GRID_X);
	localparam int YW       = $clog2(GRID_Y);
	localparam int STRIDE_X = GRID_Z;
	localparam int STRIDE_Y = GRID_Z * GRID_X;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_ISSUE,
		ST_DRAIN,
		ST_FIN_A,
		ST_FIN_B,
		ST_FIN_C,
		ST_WRITE,
		ST_DONE
	} state_t;

	// tap offset in strides, velocity sweep
	function automatic int tap_off(input logic [2:0] k);
		int o;
		case (k)
			3'd0:    o = 0;
			3'd1:    o = -1;
			3'd2:    o = 1;
			3'd3:    o = -2;
			3'd4:    o = 2;
			default: o = -3;
		endcase
		return o;
	endfunction

	state_t state_q;
	logic [fdg_pkg::CFG_WIDTH-1:0] z_begin_q, z_end_q, x_begin_q, x_end_q;
	logic [fdg_pkg::CFG_WIDTH-1:0] y_begin_q, y_end_q;
	logic [ZW-1:0] iz_q, zl_q, zh_q;
	logic [XW-1:0] ix_q, xl_q, xh_q;
	logic [YW-1:0] iy_q, yl_q, yh_q;
	logic [2:0]    k_q;
	logic [1:0]    axis_q, unit_q;
	logic          phase_q, drain_q, flag_q, inside_q;
	logic [2:0]    fs_q;
	logic          out_valid_q, status_q;
	fdg_pkg::word_t read_value_q;

	logic          in_acc;
	logic          host_inside;
	int            host_lin, pt_lin, tap_lin, stride;
	int            zl_c, zh_c, xl_c, xh_c, yl_c, yh_c;
	logic          box_empty;
	logic          z_last, x_last, y_last;
	logic [AW-1:0] host_addr, pt_addr, tap_addr;

	logic [fdg_pkg::NUM_GRIDS-1:0] mem_we;
	logic [AW-1:0]                 mem_waddr;
	fdg_pkg::word_t                mem_wdata;
	logic [AW-1:0]                 mem_raddr [fdg_pkg::NUM_GRIDS];
	fdg_pkg::word_t                mem_rdata [fdg_pkg::NUM_GRIDS];

	fdg_pkg::dp_ctl_t dp_ctl;
	fdg_pkg::word_t   dp_wr_data;
	logic             dp_sat_hit;

	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;

	// host address and box clamp
	always_comb begin
		host_inside = (int'(z_index) < GRID_Z) && (int'(x_index) < GRID_X)
			&& (int'(y_index) < GRID_Y);
		host_lin  = (int'(y_index) * GRID_X + int'(x_index)) * GRID_Z + int'(z_index);
		host_addr = host_lin[AW-1:0];
		zl_c = (int'(z_begin_q) < fdg_pkg::HALO) ? fdg_pkg::HALO : int'(z_begin_q);
		zh_c = (int'(z_end_q) > GRID_Z - fdg_pkg::HALO) ? GRID_Z - fdg_pkg::HALO
			: int'(z_end_q);
		xl_c = (int'(x_begin_q) < fdg_pkg::HALO) ? fdg_pkg::HALO : int'(x_begin_q);
		xh_c = (int'(x_end_q) > GRID_X - fdg_pkg::HALO) ? GRID_X - fdg_pkg::HALO
			: int'(x_end_q);
		yl_c = (int'(y_begin_q) < fdg_pkg::HALO) ? fdg_pkg::HALO : int'(y_begin_q);
		yh_c = (int'(y_end_q) > GRID_Y - fdg_pkg::HALO) ? GRID_Y - fdg_pkg::HALO
			: int'(y_end_q);
		box_empty = (zl_c >= zh_c) || (xl_c >= xh_c) || (yl_c >= yh_c);
	end

	// sweep point and stencil tap addresses
	always_comb begin
		pt_lin  = (int'(iy_q) * GRID_X + int'(ix_q)) * GRID_Z + int'(iz_q);
		pt_addr = pt_lin[AW-1:0];
		case (axis_q)
			2'd0:    stride = STRIDE_X;
			2'd1:    stride = STRIDE_Y;
			default: stride = 1;
		endcase
		tap_lin  = pt_lin + (tap_off(k_q) + int'(phase_q)) * stride;
		tap_addr = tap_lin[AW-1:0];
		z_last   = ({1'b0, iz_q} + 1'b1) == {1'b0, zh_q};
		x_last   = ({1'b0, ix_q} + 1'b1) == {1'b0, xh_q};
		y_last   = ({1'b0, iy_q} + 1'b1) == {1'b0, yh_q};
	end

	// memory port steering
	always_comb begin
		mem_we    = '0;
		mem_waddr = pt_addr;
		mem_wdata = dp_wr_data;
		if (state_q == ST_WRITE) begin
			if (phase_q) begin
				mem_we[fdg_pkg::G_P] = 1'b1;
			end else begin
				mem_we[fdg_pkg::G_VX + {1'b0, unit_q}] = 1'b1;
			end
		end else if (in_acc && operation == fdg_pkg::OP_LOAD && host_inside) begin
			mem_we[field_select] = 1'b1;
			mem_waddr = host_addr;
			mem_wdata = load_value;
		end
		for (int g = 0; g < fdg_pkg::NUM_GRIDS; g++) begin
			if (state_q == ST_IDLE) begin
				mem_raddr[g] = host_addr;
			end else if ((!phase_q && g == int'(fdg_pkg::G_P))
				|| (phase_q && g >= int'(fdg_pkg::G_VX) && g <= int'(fdg_pkg::G_VZ))) begin
				mem_raddr[g] = tap_addr;
			end else begin
				mem_raddr[g] = pt_addr;
			end
		end
	end

	// datapath controls
	always_comb begin
		dp_ctl.tap   = (state_q == ST_ISSUE);
		dp_ctl.first = (state_q == ST_ISSUE) && (k_q == 3'd0) && (axis_q == 2'd0);
		dp_ctl.clear = dp_ctl.first;
		dp_ctl.coef  = k_q;
		dp_ctl.axis  = axis_q;
		dp_ctl.phase = phase_q;
		dp_ctl.fin_a = (state_q == ST_FIN_A);
		dp_ctl.fin_b = (state_q == ST_FIN_B);
		dp_ctl.fin_c = (state_q == ST_FIN_C);
		dp_ctl.unit  = unit_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_begin_q <= fdg_pkg::CFG_WIDTH'(3);
			z_end_q   <= fdg_pkg::CFG_WIDTH'(29);
			x_begin_q <= fdg_pkg::CFG_WIDTH'(3);
			x_end_q   <= fdg_pkg::CFG_WIDTH'(29);
			y_begin_q <= fdg_pkg::CFG_WIDTH'(3);
			y_end_q   <= fdg_pkg::CFG_WIDTH'(29);
		end else if (cfg_we) begin
			case (cfg_index)
				fdg_pkg::CFG_Z_BEGIN: z_begin_q <= cfg_data;
				fdg_pkg::CFG_Z_END:   z_end_q   <= cfg_data;
				fdg_pkg::CFG_X_BEGIN: x_begin_q <= cfg_data;
				fdg_pkg::CFG_X_END:   x_end_q   <= cfg_data;
				fdg_pkg::CFG_Y_BEGIN: y_begin_q <= cfg_data;
				fdg_pkg::CFG_Y_END:   y_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			out_valid_q  <= 1'b0;
			status_q     <= 1'b0;
			read_value_q <= '0;
			flag_q       <= 1'b0;
			iz_q <= '0; ix_q <= '0; iy_q <= '0;
			zl_q <= '0; zh_q <= '0; xl_q <= '0; xh_q <= '0; yl_q <= '0; yh_q <= '0;
			k_q <= '0; axis_q <= '0; unit_q <= '0;
			phase_q <= 1'b0; drain_q <= 1'b0; inside_q <= 1'b0; fs_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (dp_sat_hit) begin
				flag_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (operation)
							fdg_pkg::OP_LOAD: begin
								flag_q       <= 1'b0;
								out_valid_q  <= 1'b1;
								read_value_q <= '0;
								status_q     <= 1'b0;
							end
							fdg_pkg::OP_READ: begin
								fs_q     <= field_select;
								inside_q <= host_inside;
								state_q  <= ST_READ;
							end
							fdg_pkg::OP_STEP: begin
								if (box_empty) begin
									out_valid_q  <= 1'b1;
									read_value_q <= '0;
									status_q     <= flag_q;
								end else begin
									zl_q <= zl_c[ZW-1:0]; zh_q <= zh_c[ZW-1:0];
									xl_q <= xl_c[XW-1:0]; xh_q <= xh_c[XW-1:0];
									yl_q <= yl_c[YW-1:0]; yh_q <= yh_c[YW-1:0];
									iz_q <= zl_c[ZW-1:0];
									ix_q <= xl_c[XW-1:0];
									iy_q <= yl_c[YW-1:0];
									k_q <= '0; axis_q <= '0; unit_q <= '0;
									phase_q <= 1'b0;
									state_q <= ST_ISSUE;
								end
							end
							default: begin
								out_valid_q  <= 1'b1;
								read_value_q <= '0;
								status_q     <= flag_q;
							end
						endcase
					end
				end
				ST_READ: begin
					out_valid_q  <= 1'b1;
					read_value_q <= inside_q ? mem_rdata[fs_q] : '0;
					status_q     <= flag_q;
					state_q      <= ST_IDLE;
				end
				ST_ISSUE: begin
					if (k_q == 3'd5) begin
						k_q <= '0;
						if (axis_q == 2'd2) begin
							axis_q  <= '0;
							drain_q <= 1'b0;
							state_q <= ST_DRAIN;
						end else begin
							axis_q <= axis_q + 2'd1;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				ST_DRAIN: begin
					if (drain_q) begin
						unit_q  <= '0;
						state_q <= ST_FIN_A;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_FIN_A: state_q <= ST_FIN_B;
				ST_FIN_B: state_q <= ST_FIN_C;
				ST_FIN_C: state_q <= ST_WRITE;
				ST_WRITE: begin
					if (!phase_q && unit_q != 2'd2) begin
						unit_q  <= unit_q + 2'd1;
						state_q <= ST_FIN_A;
					end else begin
						unit_q  <= '0;
						state_q <= ST_ISSUE;
						// advance point, z fastest
						if (!z_last) begin
							iz_q <= iz_q + 1'b1;
						end else begin
							iz_q <= zl_q;
							if (!x_last) begin
								ix_q <= ix_q + 1'b1;
							end else begin
								ix_q <= xl_q;
								if (!y_last) begin
									iy_q <= iy_q + 1'b1;
								end else begin
									iy_q <= yl_q;
									if (!phase_q) begin
										phase_q <= 1'b1;
									end else begin
										state_q <= ST_DONE;
									end
								end
							end
						end
					end
				end
				ST_DONE: begin
					out_valid_q  <= 1'b1;
					read_value_q <= '0;
					status_q     <= flag_q;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	// grid stores
	for (genvar g = 0; g < fdg_pkg::NUM_GRIDS; g++) begin : g_grid
		fdg_grid_mem #(
			.DEPTH(DEPTH),
			.AW   (AW)
		) u_mem (
			.clk  (clk),
			.we   (mem_we[g]),
			.waddr(mem_waddr),
			.wdata(mem_wdata),
			.raddr(mem_raddr[g]),
			.rdata(mem_rdata[g])
		);
	end

	fdg_update u_update (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (dp_ctl),
		.rdata  (mem_rdata),
		.wr_data(dp_wr_data),
		.sat_hit(dp_sat_hit)
	);

`ifndef NO_ASSERTIONS
	a_no_write_in_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ISSUE) |-> (mem_we == '0))
		else $error("grid written during stencil reads");
	a_load_clears_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && operation == fdg_pkg::OP_LOAD) |=> !flag_q)
		else $error("saturation flag not cleared by load");
	a_fin_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN_A) |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_WRITE))
		else $error("update started before accumulators settled");
`endif

endmodule
